// ----- rtl/assert_macros.svh -----
// Assertion helpers, included by the walker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge out of reset.
`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Expression that must never be true out of reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
    else $error("assertion failed");

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// ----- rtl/afm_pkg.sv -----
package afm_pkg;

  localparam int SYMBOL_BITS = 8;
  localparam int IDX_W       = SYMBOL_BITS + 1;
  localparam int NUM_SYM     = (1 << SYMBOL_BITS) + 1;
  localparam int CNT_W       = 32;
  localparam int SYM_W       = 9;
  localparam int CMP_W       = (IDX_W > SYM_W) ? IDX_W : SYM_W;

  localparam logic [IDX_W-1:0] ESC_SYM   = IDX_W'(NUM_SYM - 1);
  localparam logic [CNT_W-1:0] TOTAL_MAX = '1;
  localparam logic [CNT_W-1:0] TOTAL_RST = CNT_W'(NUM_SYM);

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic [CNT_W-1:0] low_cum;
    logic [CNT_W-1:0] high_cum;
    logic [CNT_W-1:0] total_used;
    logic [CNT_W-1:0] next_total;
    logic             error;
    logic             saturated;
  } result_t;

  // Controls from the walker to the ring of count cells.
  typedef struct packed {
    logic shift;
    logic inc;
  } ring_ctrl_t;

endpackage

// ----- rtl/adaptive_frequency_model.sv -----
// An encode or in-range decode transaction is accepted in ST_IDLE, walks the ring
// of 257 count cells in ST_WALK and presents its result in ST_EMIT; a bad decode
// target goes straight to ST_EMIT. A new transaction is taken only once the last
// has left ST_EMIT, as the ring of cells rotates through the single accumulator.
// Reset (rst_ni low, asynchronous) sets every count to one and the total to 257.
module adaptive_frequency_model
  import afm_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [47:0]  s_axis_tdata,  // symbol_in [8:0], target [40:9], zero [47:41]
  input  logic         s_axis_tuser,  // op
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata,  // symbol_out, low_cum, high_cum, total_used,
                                      // next_total, zero [143:137]
  output logic [1:0]   m_axis_tuser   // error [0], saturated [1]
);

  // The symbol counts live in a ring of cells. During a walk the ring shifts
  // once per cycle toward cell zero, so the head cell presents the count of
  // symbol k at walk step k. The head value re-enters at the tail, plus one
  // when the walker marks it as the symbol of this transaction. After a full
  // turn of NUM_SYM shifts every count is back in its own cell.

  logic [CNT_W-1:0] cnt [NUM_SYM];
  ring_ctrl_t       ring;
  logic             res_valid;
  logic             res_ready;
  result_t          res;
  result_t          out_q;
  logic             out_valid_q;

  for (genvar i = 0; i < NUM_SYM; i++) begin : g_ring
    if (i == NUM_SYM - 1) begin : g_tail
      afm_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(ring.shift),
        .inc_i  (ring.inc),
        .next_i (cnt[0]),
        .count_o(cnt[i])
      );
    end else begin : g_body
      afm_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .shift_i(ring.shift),
        .inc_i  (1'b0),
        .next_i (cnt[i+1]),
        .count_o(cnt[i])
      );
    end
  end

  // The walker owns the running total, the cumulative accumulator and the
  // search. It takes one transaction at a time.
  afm_walker u_walker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .op_i       (s_axis_tuser),
    .symbol_i   (s_axis_tdata[8:0]),
    .target_i   (s_axis_tdata[40:9]),
    .head_i     (cnt[0]),
    .ring_o     (ring),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // Output register: a finished result waits here, so the walker is free to
  // accept and process the next transaction while the sink stalls.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_q.next_total, out_q.total_used, out_q.high_cum,
                          out_q.low_cum, out_q.symbol};
  assign m_axis_tuser  = {out_q.saturated, out_q.error};

endmodule

// ----- rtl/afm_cell.sv -----
module afm_cell
  import afm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic             inc_i,
  input  logic [CNT_W-1:0] next_i,
  output logic [CNT_W-1:0] count_o
);

  logic [CNT_W-1:0] count_q, count_d;

  // On a shift the cell takes its neighbor's count, bumped by one when asked.
  assign count_d = next_i + {{(CNT_W-1){1'b0}}, inc_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CNT_W'(1);
    end else if (shift_i) begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

// ----- rtl/afm_walker.sv -----
`include "assert_macros.svh"

module afm_walker
  import afm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             op_i,
  input  logic [SYM_W-1:0] symbol_i,
  input  logic [CNT_W-1:0] target_i,
  input  logic [CNT_W-1:0] head_i,
  output ring_ctrl_t       ring_o,
  output logic             res_valid_o,
  input  logic             res_ready_i,
  output result_t          res_o
);

  state_e           state_q, state_d;
  logic [IDX_W-1:0] step_q;
  logic [CNT_W-1:0] acc_q;
  logic             found_q;
  op_e              op_q;
  logic [IDX_W-1:0] sym_q;
  logic [CNT_W-1:0] target_q;
  logic [CNT_W-1:0] total_q;
  logic [CNT_W-1:0] used_q;
  logic             sat_q;
  logic             err_q;
  logic [IDX_W-1:0] rsym_q;
  logic [CNT_W-1:0] rlow_q;
  logic [CNT_W-1:0] rhigh_q;

  logic             accept;
  logic             bad_target;
  logic [CMP_W-1:0] sym_ext;
  logic [IDX_W-1:0] sym_clamped;
  logic [CNT_W:0]   sum;
  logic             hit;
  logic             last_step;
  logic [CNT_W-1:0] next_total;

  assign accept     = in_valid_i && in_ready_o;
  assign bad_target = (op_e'(op_i) == OP_DECODE) && (target_i >= total_q);
  assign sym_ext    = CMP_W'(symbol_i);
  assign sym_clamped = (sym_ext > CMP_W'(ESC_SYM)) ? ESC_SYM : IDX_W'(sym_ext);

  assign sum       = {1'b0, acc_q} + {1'b0, head_i};
  assign last_step = (step_q == ESC_SYM);

  always_comb begin
    hit = 1'b0;
    if (state_q == ST_WALK && !found_q) begin
      if (op_q == OP_ENCODE) begin
        hit = (step_q == sym_q);
      end else begin
        hit = last_step || (sum > {1'b0, target_q});
      end
    end
  end

  assign next_total = (err_q || sat_q) ? used_q : used_q + CNT_W'(1);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = bad_target ? ST_EMIT : ST_WALK;
        end
      end
      ST_WALK: begin
        if (last_step) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_ready_o   = 1'b0;
    res_valid_o  = 1'b0;
    ring_o.shift = 1'b0;
    ring_o.inc   = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_WALK: begin
        ring_o.shift = 1'b1;
        ring_o.inc   = hit && !sat_q;
      end
      ST_EMIT: res_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      total_q <= TOTAL_RST;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        found_q <= 1'b0;
      end else if (hit) begin
        found_q <= 1'b1;
      end
      if (state_q == ST_EMIT && res_ready_i) begin
        total_q <= next_total;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= op_e'(op_i);
      sym_q    <= sym_clamped;
      target_q <= target_i;
      used_q   <= total_q;
      step_q   <= '0;
      acc_q    <= '0;
      err_q    <= bad_target;
      sat_q    <= !bad_target && (total_q == TOTAL_MAX);
      rsym_q   <= '0;
      rlow_q   <= '0;
      rhigh_q  <= '0;
    end else if (state_q == ST_WALK) begin
      step_q <= step_q + IDX_W'(1);
      if (hit) begin
        rsym_q  <= step_q;
        rlow_q  <= acc_q;
        rhigh_q <= sum[CNT_W-1:0];
      end else if (!found_q) begin
        acc_q <= sum[CNT_W-1:0];
      end
    end
  end

  assign res_o.symbol     = SYM_W'(rsym_q);
  assign res_o.low_cum    = rlow_q;
  assign res_o.high_cum   = rhigh_q;
  assign res_o.total_used = used_q;
  assign res_o.next_total = next_total;
  assign res_o.error      = err_q;
  assign res_o.saturated  = sat_q;

  `ASSERT_CLK(a_inc_only_on_shift, clk_i, rst_ni, ring_o.inc |-> ring_o.shift)
  `ASSERT_NEVER(a_single_hit, clk_i, rst_ni, found_q && hit)
  `ASSERT_CLK(a_walk_finds, clk_i, rst_ni,
              (state_q == ST_WALK && last_step) |=> found_q)
  `ASSERT_CLK(a_err_no_walk, clk_i, rst_ni, (state_q == ST_WALK) |-> !err_q)

endmodule

// ----- test/adaptive_frequency_model_test.sv -----
`timescale 1ns / 1ps

module adaptive_frequency_model_test;
  import afm_pkg::*;

  // A whole transaction walks the ring of 257 count cells. The limit below
  // covers every phase with room to spare, including the worst stalls on
  // both sides.
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int DRAIN_CYCLES = 300;
  localparam int RANDOM_PER_PHASE = 150;

  // One request as the coder hands it to the model.
  typedef struct {
    op_e              op;
    logic [SYM_W-1:0] symbol_in;
    logic [CNT_W-1:0] target;
  } freq_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [47:0]  s_axis_tdata = '0;   // symbol_in [8:0], target [40:9], zero [47:41]
  logic         s_axis_tuser = 1'b0; // op
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;        // symbol_out, low_cum, high_cum, total_used,
                                     // next_total, zero [143:137]
  logic [1:0]   m_axis_tuser;        // error [0], saturated [1]

  adaptive_frequency_model i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Requests waiting to be driven, and the intervals the model must return,
  // oldest first.
  freq_req_t queued_requests[$];
  result_t   pending_intervals[$];

  // Private copy of the frequency table, updated when a request is accepted.
  logic [CNT_W-1:0] freq_count[NUM_SYM];
  logic [CNT_W-1:0] freq_total;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int fail_count = 0;
  int results_checked = 0;
  int encode_count = 0;
  int decode_count = 0;
  int bad_target_count = 0;
  int unsigned cycle_count = 0;

  // Applies one accepted request to the table copy and returns the interval
  // that the block should report for it.
  function automatic result_t step_frequency_table(input freq_req_t req);
    result_t          res;
    logic [IDX_W-1:0] sym;
    logic [CNT_W:0]   acc;
    res = '0;
    sym = '0;
    acc = '0;
    res.total_used = freq_total;
    if (req.op == OP_ENCODE) begin
      // Symbols past the escape fold onto the escape.
      sym = (req.symbol_in > ESC_SYM) ? ESC_SYM : IDX_W'(req.symbol_in);
      for (int i = 0; i < int'(sym); i++) acc += {1'b0, freq_count[i]};
    end else if (req.target >= freq_total) begin
      res.error = 1'b1;
    end else begin
      // Cumulative search: stop at the first symbol whose interval holds
      // the target. The escape is the last possible stop.
      while (sym < ESC_SYM && acc + {1'b0, freq_count[sym]} <= {1'b0, req.target}) begin
        acc += {1'b0, freq_count[sym]};
        sym++;
      end
    end
    if (!res.error) begin
      res.symbol   = SYM_W'(sym);
      res.low_cum  = acc[CNT_W-1:0];
      res.high_cum = acc[CNT_W-1:0] + freq_count[sym];
      // A total at its maximum freezes the table but the item is answered.
      if (freq_total == TOTAL_MAX) begin
        res.saturated = 1'b1;
      end else begin
        freq_count[sym] = freq_count[sym] + CNT_W'(1);
        freq_total = freq_total + CNT_W'(1);
      end
    end
    res.next_total = freq_total;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
                                 input logic [CNT_W-1:0] want);
    $display("[%0t] mismatch on result %0d: %s got 0x%0h, expected 0x%0h",
             $realtime, results_checked, what, got, want);
    fail_count++;
  endtask

  // Driver: presents queued requests on the slave side, holding each one
  // until the model accepts it, and inserts random idle cycles.
  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    freq_req_t nxt;
    static freq_req_t held;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      s_axis_tuser  <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_intervals.push_back(step_frequency_table(held));
        if (held.op == OP_ENCODE) encode_count++;
        else if (held.target >= pending_intervals[$].total_used) bad_target_count++;
        else decode_count++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (queued_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = queued_requests.pop_front();
          held = nxt;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {7'b0, nxt.target, nxt.symbol_in};
          s_axis_tuser  <= nxt.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls the master side at random and checks every accepted
  // result field by field against the oldest expected interval.
  always @(posedge clk_i or negedge rst_ni) begin : check_results
    result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_intervals.size() == 0) begin
          report_mismatch("unexpected result, symbol", CNT_W'(m_axis_tdata[8:0]), '0);
        end else begin
          want = pending_intervals.pop_front();
          if (m_axis_tdata[8:0] !== want.symbol)
            report_mismatch("symbol_out", CNT_W'(m_axis_tdata[8:0]), CNT_W'(want.symbol));
          if (m_axis_tdata[40:9] !== want.low_cum)
            report_mismatch("low_cum", m_axis_tdata[40:9], want.low_cum);
          if (m_axis_tdata[72:41] !== want.high_cum)
            report_mismatch("high_cum", m_axis_tdata[72:41], want.high_cum);
          if (m_axis_tdata[104:73] !== want.total_used)
            report_mismatch("total_used", m_axis_tdata[104:73], want.total_used);
          if (m_axis_tdata[136:105] !== want.next_total)
            report_mismatch("next_total", m_axis_tdata[136:105], want.next_total);
          if (m_axis_tuser[0] !== want.error)
            report_mismatch("error", CNT_W'(m_axis_tuser[0]), CNT_W'(want.error));
          if (m_axis_tuser[1] !== want.saturated)
            report_mismatch("saturated", CNT_W'(m_axis_tuser[1]), CNT_W'(want.saturated));
          results_checked++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycle_count, pending_intervals.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // The stimulus side keeps its own running total so that it can aim decode
  // targets inside or just outside the range that the block will see.
  logic [CNT_W-1:0] plan_total;
  logic [SYM_W-1:0] hot_symbols[4];

  task automatic queue_request(input op_e op, input logic [SYM_W-1:0] symbol_in,
                               input logic [CNT_W-1:0] target);
    freq_req_t req;
    req.op = op;
    req.symbol_in = symbol_in;
    req.target = target;
    queued_requests.push_back(req);
    if ((op == OP_ENCODE || target < plan_total) && plan_total != TOTAL_MAX)
      plan_total++;
  endtask

  // Blocks until every request has been sent and every result has come back.
  task automatic wait_until_idle();
    while (queued_requests.size() != 0 || s_axis_tvalid || pending_intervals.size() != 0)
      @(posedge clk_i);
  endtask

  // Mostly well-formed traffic: encodes that favor a few hot symbols so the
  // counts grow uneven, decodes aimed inside the current total, and a tenth
  // of out-of-range targets mixed in.
  task automatic run_random_phase(input int send_pct, input int recv_pct);
    logic [CNT_W-1:0] tgt;
    int unsigned      pick;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        if ($urandom_range(1) == 0)
          queue_request(OP_ENCODE, hot_symbols[$urandom_range(3)], $urandom);
        else
          queue_request(OP_ENCODE, SYM_W'($urandom_range(511)), $urandom);
      end else if (pick < 90) begin
        case ($urandom_range(9))
          0: tgt = '0;
          1: tgt = plan_total - 1;
          default: tgt = $urandom_range(plan_total - 1, 0);
        endcase
        queue_request(OP_DECODE, SYM_W'($urandom_range(511)), tgt);
      end else begin
        tgt = $urandom;
        if (tgt < plan_total) tgt = ~tgt;
        if ($urandom_range(3) == 0) tgt = plan_total;
        queue_request(OP_DECODE, SYM_W'($urandom_range(511)), tgt);
      end
    end
    wait_until_idle();
  endtask

  initial begin
    for (int i = 0; i < NUM_SYM; i++) freq_count[i] = CNT_W'(1);
    freq_total = TOTAL_RST;
    plan_total = TOTAL_RST;
    foreach (hot_symbols[i]) hot_symbols[i] = SYM_W'($urandom_range(NUM_SYM - 1));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening: the symbol extremes, the escape and the clamp above
    // it, decode targets at both ends of the range and just past it.
    send_idle_pct = 12;
    recv_idle_pct = 49;
    queue_request(OP_ENCODE, 9'd0, 32'h0000_0000);
    queue_request(OP_ENCODE, 9'd255, 32'hFFFF_FFFF);
    queue_request(OP_ENCODE, 9'd256, 32'h5555_5555);
    queue_request(OP_ENCODE, 9'd257, 32'h0000_0001);
    queue_request(OP_ENCODE, 9'd511, 32'hAAAA_AAAA);
    queue_request(OP_DECODE, 9'd0, 32'h0000_0000);
    queue_request(OP_DECODE, 9'd511, plan_total - 1);
    queue_request(OP_DECODE, 9'd0, plan_total);
    queue_request(OP_DECODE, 9'd0, 32'hFFFF_FFFF);
    queue_request(OP_DECODE, 9'd511, plan_total / 2);
    queue_request(OP_DECODE, 9'd1, 32'h0000_0001);
    queue_request(OP_ENCODE, 9'd1, 32'h8000_0000);
    queue_request(OP_DECODE, 9'd0, 32'h0000_0002);
    queue_request(OP_ENCODE, 9'd128, 32'h7FFF_FFFF);
    queue_request(OP_DECODE, 9'd256, plan_total - 2);
    queue_request(OP_DECODE, 9'd0, plan_total + 1);
    wait_until_idle();

    run_random_phase(12, 49);
    run_random_phase(49, 12);
    run_random_phase(0, 0);

    // Give the block time to emit anything stray before judging the run.
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d encode, %0d in-range decode and %0d bad-target transactions.",
             encode_count, decode_count, bad_target_count);
    $display("Checked %0d results; table total grew from %0d to %0d.",
             results_checked, TOTAL_RST, freq_total);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
